### sv/chmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chmc_pkg: shared constants for the convex hull block
// Default sizes for the point store and the coordinate width.
// ----------------------------------------------------------------------------
package chmc_pkg;
  localparam int unsigned DefMaxPoints = 32;
  localparam int unsigned DefCoordBits = 16;
  localparam int unsigned PortBits     = 16;
endpackage
`default_nettype wire

### sv/chmc_turn.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chmc_turn: shared cross product unit
// Computes the sign test of (a-o) x (b-o), one product per phase (ph1_r, then ph2_r).
// ----------------------------------------------------------------------------
module chmc_turn #(
  parameter int unsigned COORD_BITS = chmc_pkg::DefCoordBits
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [COORD_BITS-1:0] ox,
  input  wire logic signed [COORD_BITS-1:0] oy,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  output logic                              done,
  output logic                              nonpos
);
  localparam int unsigned DB = COORD_BITS + 1;
  localparam int unsigned PB = 2 * DB;

  logic signed [DB-1:0] dax_r, day_r, dbx_r, dby_r;
  logic signed [PB-1:0] p1_r;
  logic                 ph1_r, ph2_r;
  logic signed [PB-1:0] prod;
  logic signed [PB:0]   diff;

  // One multiplier, shared by both products.
  always_comb begin
    if (ph1_r) begin
      prod = dax_r * dby_r;
    end else begin
      prod = day_r * dbx_r;
    end
    diff = {p1_r[PB-1], p1_r} - {prod[PB-1], prod};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph1_r  <= 1'b0;
      ph2_r  <= 1'b0;
      done   <= 1'b0;
      nonpos <= 1'b0;
    end else begin
      ph1_r <= start;
      ph2_r <= ph1_r;
      done  <= ph2_r;
      if (ph2_r) begin
        nonpos <= diff[PB] || (diff == '0);
      end
    end
    if (start) begin
      dax_r <= DB'(ax) - DB'(ox);
      day_r <= DB'(ay) - DB'(oy);
      dbx_r <= DB'(bx) - DB'(ox);
      dby_r <= DB'(by) - DB'(oy);
    end
    if (ph1_r) begin
      p1_r <= prod;
    end
  end

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ph2_r |=> done) else $error("turn result missing");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ph1_r |-> !start) else $error("turn unit restarted while busy");
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ph1_r) else $error("phase not entered");
`endif
endmodule
`default_nettype wire

### sv/convex_hull_monotone_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// convex_hull_monotone_chain: convex hull of a point set, monotone chain
// Stores points, sorts them and builds the hull with one shared turn unit.
// ----------------------------------------------------------------------------
// Usage. Points enter as words on the in_ channel (valid/ready), one per cycle
// while loading. The word with in_last_point set closes the set. Points past
// MAX_POINTS are dropped and reported through out_overflow on every result.
// After the last point the block drops in_ready and works alone: an insertion
// sort over the point memory (each step a compare state and a move state),
// then the lower and upper chains, where each stack test holds the shared
// cross product unit for two multiplies and each fetch or push is a state of
// its own, with at most about 4n tests over both chains.
// The hull is then sent on the out_ channel, one vertex per word in
// counter-clockwise order from the least (x, y), with out_last_vertex on the
// final word, each word passing through S_OUT_RD and S_OUT_HOLD. A set of one
// point yields a single word with out_vertex_valid clear. The receiver may
// stall freely: the sender holds the word until out_ready. The next set is
// taken once the last word is delivered. A synchronous reset (rst_n low)
// returns the block to loading an empty set; memories need no clearing pass.
// ----------------------------------------------------------------------------
module convex_hull_monotone_chain #(
  parameter int unsigned MAX_POINTS = chmc_pkg::DefMaxPoints,
  parameter int unsigned COORD_BITS = chmc_pkg::DefCoordBits
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_point_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_y,
  input  wire logic                         in_last_point,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [COORD_BITS-1:0]      out_hull_x,
  output logic signed [COORD_BITS-1:0]      out_hull_y,
  output logic                              out_vertex_valid,
  output logic                              out_overflow,
  output logic                              out_last_vertex
);
  import chmc_pkg::*;

  localparam int unsigned IB = $clog2(MAX_POINTS);
  localparam int unsigned CB = $clog2(MAX_POINTS + 1);
  localparam int unsigned SD = MAX_POINTS + 1;
  localparam int unsigned SB = $clog2(SD + 1);
  localparam int unsigned CW = COORD_BITS;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pt_t;

  typedef enum logic [3:0] {
    S_LOAD, S_SORT_RD, S_SORT_CMP, S_SORT_PUT, S_HULL_RD, S_HULL_TST,
    S_HULL_WAIT, S_OUT_RD, S_OUT_HOLD
  } state_t;

  // Memories
  pt_t store_mem [MAX_POINTS];
  pt_t stack_mem [SD];

  state_t        state_r;
  logic [CB-1:0] count_r;
  logic          ovf_r;
  logic [CB-1:0] i_r;     // outer index
  logic [CB:0]   j_r;     // sort inner index, signed-ish (extra bit)
  pt_t           key_r;   // element being inserted / current point
  pt_t           rd_r;    // registered store read
  logic [SB-1:0] k_r;     // stack depth
  logic [SB-1:0] floor_r;
  logic          upper_r;
  logic          left_r;  // the last test turned left, so push without testing
  pt_t           s1_r, s2_r;
  logic [SB-1:0] h_r;
  logic [SB-1:0] o_r;
  logic          turn_go;
  logic          turn_done, turn_np;

  pt_t           in_pt;
  logic          key_before;

  assign in_pt.x = in_point_x;
  assign in_pt.y = in_point_y;
  assign in_ready = (state_r == S_LOAD);
  assign key_before = (key_r.x != rd_r.x) ? (key_r.x < rd_r.x) : (key_r.y < rd_r.y);

  chmc_turn #(.COORD_BITS(COORD_BITS)) u_turn (
    .clk(clk), .rst_n(rst_n), .start(turn_go),
    .ox(s2_r.x), .oy(s2_r.y), .ax(s1_r.x), .ay(s1_r.y),
    .bx(key_r.x), .by(key_r.y), .done(turn_done), .nonpos(turn_np)
  );

  assign turn_go = (state_r == S_HULL_TST) && (k_r >= floor_r) && !left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      left_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            if (count_r < CB'(MAX_POINTS)) begin
              store_mem[count_r[IB-1:0]] <= in_pt;
              count_r <= count_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_last_point) begin
              i_r     <= CB'(1);
              state_r <= S_SORT_RD;
            end
          end
        end
        // Insertion sort: key = store[i], walk j down shifting larger entries.
        S_SORT_RD: begin
          if (i_r >= count_r) begin
            i_r     <= '0;
            k_r     <= '0;
            floor_r <= SB'(2);
            upper_r <= 1'b0;
            left_r  <= 1'b0;
            state_r <= (count_r >= CB'(2)) ? S_HULL_RD : S_OUT_RD;
          end else begin
            key_r   <= store_mem[i_r[IB-1:0]];
            rd_r    <= store_mem[i_r[IB-1:0] - 1'b1];
            j_r     <= {1'b0, i_r} - 1'b1;
            state_r <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          if (key_before) begin
            store_mem[j_r[IB-1:0] + 1'b1] <= rd_r;
            j_r     <= j_r - 1'b1;
            state_r <= S_SORT_PUT;
          end else begin
            store_mem[j_r[IB-1:0] + 1'b1] <= key_r;
            i_r     <= i_r + 1'b1;
            state_r <= S_SORT_RD;
          end
        end
        // Once j has run below zero the key belongs at the bottom.
        S_SORT_PUT: begin
          if (j_r[CB]) begin
            store_mem[0] <= key_r;
            i_r          <= i_r + 1'b1;
            state_r      <= S_SORT_RD;
          end else begin
            rd_r    <= store_mem[j_r[IB-1:0]];
            state_r <= S_SORT_CMP;
          end
        end
        // Hull: fetch point i and the top two stack entries.
        S_HULL_RD: begin
          key_r <= store_mem[i_r[IB-1:0]];
          if (k_r >= SB'(2)) begin
            s1_r <= stack_mem[k_r - SB'(1)];
            s2_r <= stack_mem[k_r - SB'(2)];
          end
          state_r <= S_HULL_TST;
        end
        S_HULL_TST: begin
          if ((k_r >= floor_r) && !left_r) begin
            state_r <= S_HULL_WAIT;
          end else begin
            stack_mem[k_r] <= key_r;
            k_r    <= k_r + 1'b1;
            left_r <= 1'b0;
            if (!upper_r) begin
              if (i_r == count_r - 1'b1) begin
                upper_r <= 1'b1;
                floor_r <= k_r + SB'(2);
                i_r     <= count_r - CB'(2);
                state_r <= S_HULL_RD;
              end else begin
                i_r     <= i_r + 1'b1;
                state_r <= S_HULL_RD;
              end
            end else if (i_r == '0) begin
              h_r     <= k_r;
              o_r     <= '0;
              state_r <= S_OUT_RD;
            end else begin
              i_r     <= i_r - 1'b1;
              state_r <= S_HULL_RD;
            end
          end
        end
        S_HULL_WAIT: begin
          if (turn_done) begin
            if (turn_np) begin
              k_r     <= k_r - 1'b1;
              state_r <= S_HULL_RD;
            end else begin
              left_r  <= 1'b1;
              state_r <= S_HULL_TST;
            end
          end
        end
        S_OUT_RD: begin
          if (count_r < CB'(2)) begin
            out_hull_x       <= '0;
            out_hull_y       <= '0;
            out_vertex_valid <= 1'b0;
            out_last_vertex  <= 1'b1;
          end else begin
            out_hull_x       <= stack_mem[o_r].x;
            out_hull_y       <= stack_mem[o_r].y;
            out_vertex_valid <= 1'b1;
            out_last_vertex  <= (o_r == h_r - SB'(1));
          end
          out_overflow <= ovf_r;
          out_valid    <= 1'b1;
          state_r      <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last_vertex) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              o_r     <= o_r + 1'b1;
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !in_ready) else $error("ready while busy");
  a_out_only_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_OUT_HOLD)) else $error("stray output word");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CB'(MAX_POINTS)) else $error("point count overrun");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= SB'(SD) || state_r == S_LOAD) else $error("stack overrun");
`endif
endmodule
`default_nettype wire
